### design/triangle_normal_tangent_gen_assert.svh
// Assertion macros for the triangle normal and tangent generator.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef TRIANGLE_NORMAL_TANGENT_GEN_ASSERT_SVH
`define TRIANGLE_NORMAL_TANGENT_GEN_ASSERT_SVH
`ifndef SYNTH
`define TNTG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define TNTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define TNTG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TNTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/tntg_pkg.sv
// Shared widths, constants and the result beat layout of the
// triangle normal and tangent generator. No dependencies.
`default_nettype none

package tntg_pkg;

    localparam int unsigned S_TDATA_W  = 176;
    localparam int unsigned M_TDATA_W  = 120;
    localparam int unsigned RAW_MAG_W  = 61;
    localparam int unsigned ACC_W      = 66;
    localparam int unsigned NUM_W      = 47;
    localparam int unsigned Q_W        = 15;

    localparam logic [1:0] SLOT_THIRD  = 2'd2;
    localparam logic [1:0] LAST_BEAT   = 2'd2;
    localparam logic [1:0] LAST_COMP   = 2'd2;
    localparam logic [3:0] MUL_LAST    = 4'd13;
    localparam logic [3:0] DIV_LAST    = 4'd14;
    localparam logic signed [15:0] Q14_ONE = 16'sd16384;
    localparam logic [63:0] SQRT_FIRST_BIT = 64'h4000_0000_0000_0000;

    // Result beat, last field in the lowest bits.
    typedef struct packed {
        logic [5:0]  pad;
        logic        degenerate;
        logic        handed_negative;
        logic [15:0] tangent_z;
        logic [15:0] tangent_y;
        logic [15:0] tangent_x;
        logic [15:0] normal_z;
        logic [15:0] normal_y;
        logic [15:0] normal_x;
        logic [15:0] out_vertex_index;
    } out_beat_t;

endpackage

`default_nettype wire

### design/triangle_normal_tangent_gen.sv
// Top level of the triangle normal and tangent generator.
// Depends on tntg_pkg and triangle_normal_tangent_gen_assert.svh.
`default_nettype none
`include "triangle_normal_tangent_gen_assert.svh"

// Vertices stream in one transfer each, in triangle order. The first two
// vertices of a triangle are held in registers. The third vertex starts
// the computation: the block drops s_tready, forms the edges and texcoord
// deltas, and runs everything through one shared 32x32 multiplier, one
// 64-bit square root step and one restoring divider under a small sequencer.
// Steps for the third vertex: range reduction of the edges and texcoord
// deltas, the fourteen products (multiply, then accumulate), and for each
// of the normal and the tangent range reduction, the squared length, 32
// square root steps and one divide per component; the tangent is skipped
// when the texcoord determinant is zero. The three results then leave as
// three output transfers, the third with tlast set; a new vertex is taken
// only after the third result transfer. A vertex with tlast set as first
// or second of a triangle drops the partial triangle. A zero normal, a zero
// tangent or a zero determinant yields a zero vector for the result
// concerned and sets the degenerate flag.
module triangle_normal_tangent_gen (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // vertex_index[15:0], position_x[47:16], position_y[79:48],
    // position_z[111:80], tex_u[143:112], tex_v[175:144]
    input  logic [tntg_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,   // end_of_list
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_vertex_index[15:0], normal_x[31:16], normal_y[47:32],
    // normal_z[63:48], tangent_x[79:64], tangent_y[95:80],
    // tangent_z[111:96], handed_negative[112], degenerate[113], zeros above
    output logic [tntg_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast    // last_of_run
);
    import tntg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_REDUCE, ST_MUL, ST_ACC, ST_NSHIFT, ST_SQMUL, ST_SQACC,
        ST_CHKLEN, ST_SQRT, ST_DIVINIT, ST_DIV, ST_FINVEC, ST_EMIT
    } state_t;

    state_t      state_reg;
    logic [1:0]  slot_reg;
    logic [3:0]  mcnt_reg;
    logic [1:0]  comp_reg;
    logic [3:0]  dcnt_reg;
    logic [1:0]  out_cnt_reg;
    logic        vsel_reg;

    // Held vertices of the open triangle.
    logic signed [31:0] hp_reg [6];
    logic signed [31:0] ht_reg [4];
    logic [15:0]        hi_reg [2];
    logic [15:0]        idx2_reg;

    // Edges and texcoord deltas (du0, du1, dv0, dv1) in sign and magnitude.
    logic               e_sgn_reg [6];
    logic [31:0]        e_mag_reg [6];
    logic               tx_sgn_reg [4];
    logic [31:0]        tx_mag_reg [4];

    logic signed [63:0]     prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic               det_neg_reg;
    logic               det_zero_reg;
    logic               n_sgn_reg [3];
    logic [RAW_MAG_W-1:0] n_mag_reg [3];
    logic               tr_sgn_reg [3];
    logic [RAW_MAG_W-1:0] tr_mag_reg [3];

    logic [63:0]        sq_x_reg;
    logic [63:0]        sq_r_reg;
    logic [63:0]        sq_b_reg;
    logic [NUM_W-1:0]   rem_reg;
    logic [NUM_W-1:0]   den_reg;
    logic [Q_W-1:0]     q_reg;

    logic signed [15:0] on_reg [3];
    logic signed [15:0] ot_reg [3];
    logic               ok_n_reg;
    logic               ok_t_reg;

    // Input unpacking and edge formation.
    logic               s_fire;
    logic [15:0]        in_idx;
    logic signed [31:0] in_pos [3];
    logic signed [31:0] in_u;
    logic signed [31:0] in_v;
    logic [32:0]        edge_d [6];
    logic [32:0]        tex_d [4];
    logic [32:0]        edge_abs [6];
    logic [32:0]        tex_abs [4];

    assign s_fire    = s_tvalid && s_tready;
    assign in_idx    = s_tdata[15:0];
    assign in_pos[0] = s_tdata[47:16];
    assign in_pos[1] = s_tdata[79:48];
    assign in_pos[2] = s_tdata[111:80];
    assign in_u      = s_tdata[143:112];
    assign in_v      = s_tdata[175:144];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            edge_d[i]     = {hp_reg[3+i][31], hp_reg[3+i]} - {hp_reg[i][31], hp_reg[i]};
            edge_d[3+i]   = {in_pos[i][31], in_pos[i]} - {hp_reg[i][31], hp_reg[i]};
        end
        tex_d[0] = {ht_reg[2][31], ht_reg[2]} - {ht_reg[0][31], ht_reg[0]};
        tex_d[1] = {in_u[31], in_u} - {ht_reg[0][31], ht_reg[0]};
        tex_d[2] = {ht_reg[3][31], ht_reg[3]} - {ht_reg[1][31], ht_reg[1]};
        tex_d[3] = {in_v[31], in_v} - {ht_reg[1][31], ht_reg[1]};
        for (int i = 0; i < 6; i++)
        begin
            edge_abs[i] = edge_d[i][32] ? (~edge_d[i] + 33'd1) : edge_d[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            tex_abs[i] = tex_d[i][32] ? (~tex_d[i] + 33'd1) : tex_d[i];
        end
    end

    // Range reduction flags: every magnitude of a group must fall below 2^30.
    logic [31:0] e_or;
    logic        e_big;
    logic        du_big;
    logic        dv_big;

    always_comb
    begin
        e_or = '0;
        for (int i = 0; i < 6; i++)
        begin
            e_or = e_or | e_mag_reg[i];
        end
    end

    assign e_big  = |e_or[31:30];
    assign du_big = |(tx_mag_reg[0][31:30] | tx_mag_reg[1][31:30]);
    assign dv_big = |(tx_mag_reg[2][31:30] | tx_mag_reg[3][31:30]);

    // Reduced values in two's complement for the multiplier.
    logic signed [31:0] op_e [6];
    logic signed [31:0] op_t [4];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            op_e[i] = e_sgn_reg[i] ? -$signed({1'b0, e_mag_reg[i][30:0]})
                                   : $signed({1'b0, e_mag_reg[i][30:0]});
        end
        for (int i = 0; i < 4; i++)
        begin
            op_t[i] = tx_sgn_reg[i] ? -$signed({1'b0, tx_mag_reg[i][30:0]})
                                    : $signed({1'b0, tx_mag_reg[i][30:0]});
        end
    end

    // Component under work in the normalizer.
    logic [RAW_MAG_W-1:0] cur_mag;
    logic                 cur_sgn;

    always_comb
    begin
        unique case (comp_reg)
            2'd0:    begin cur_mag = n_mag_reg[0]; cur_sgn = n_sgn_reg[0]; end
            2'd1:    begin cur_mag = n_mag_reg[1]; cur_sgn = n_sgn_reg[1]; end
            2'd2:    begin cur_mag = n_mag_reg[2]; cur_sgn = n_sgn_reg[2]; end
            default: begin cur_mag = '0;           cur_sgn = 1'b0;         end
        endcase
    end

    // Shared multiplier. The product table pairs up as det, normal x/y/z,
    // then tangent x/y/z, each as first product minus second product.
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_SQMUL)
        begin
            mul_a = $signed({1'b0, cur_mag[30:0]});
            mul_b = $signed({1'b0, cur_mag[30:0]});
        end
        else
        begin
            unique case (mcnt_reg)
                4'd0:    begin mul_a = op_t[0]; mul_b = op_t[3]; end
                4'd1:    begin mul_a = op_t[1]; mul_b = op_t[2]; end
                4'd2:    begin mul_a = op_e[1]; mul_b = op_e[5]; end
                4'd3:    begin mul_a = op_e[2]; mul_b = op_e[4]; end
                4'd4:    begin mul_a = op_e[2]; mul_b = op_e[3]; end
                4'd5:    begin mul_a = op_e[0]; mul_b = op_e[5]; end
                4'd6:    begin mul_a = op_e[0]; mul_b = op_e[4]; end
                4'd7:    begin mul_a = op_e[1]; mul_b = op_e[3]; end
                4'd8:    begin mul_a = op_t[3]; mul_b = op_e[0]; end
                4'd9:    begin mul_a = op_t[2]; mul_b = op_e[3]; end
                4'd10:   begin mul_a = op_t[3]; mul_b = op_e[1]; end
                4'd11:   begin mul_a = op_t[2]; mul_b = op_e[4]; end
                4'd12:   begin mul_a = op_t[3]; mul_b = op_e[2]; end
                4'd13:   begin mul_a = op_t[2]; mul_b = op_e[5]; end
                default: begin mul_a = '0;      mul_b = '0;      end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    // Accumulator paths.
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] diff;
    logic                    diff_neg;
    logic [ACC_W-1:0]        diff_abs;
    logic [RAW_MAG_W-1:0]    diff_mag;

    assign prod_ext = {{(ACC_W-64){prod_reg[63]}}, prod_reg};
    assign diff     = acc_reg - prod_ext;
    assign diff_neg = diff[ACC_W-1];
    assign diff_abs = diff_neg ? (~diff + 1'b1) : diff;
    assign diff_mag = diff_abs[RAW_MAG_W-1:0];

    // Normalizer range reduction: all magnitudes below 2^31.
    logic [RAW_MAG_W-1:0] n_or;
    logic                 n_big8;
    logic                 n_big1;

    assign n_or   = n_mag_reg[0] | n_mag_reg[1] | n_mag_reg[2];
    assign n_big8 = |n_or[RAW_MAG_W-1:39];
    assign n_big1 = |n_or[RAW_MAG_W-1:31];

    // One square root step and one divide step.
    logic [63:0]      sq_sum;
    logic             sq_ge;
    logic             div_ge;
    logic [Q_W-1:0]   q_next;
    logic signed [15:0] q_signed;
    logic [31:0]      len;

    assign sq_sum   = sq_r_reg + sq_b_reg;
    assign sq_ge    = sq_x_reg >= sq_sum;
    assign len      = sq_r_reg[31:0];
    assign div_ge   = rem_reg >= den_reg;
    assign q_next   = {q_reg[Q_W-2:0], div_ge};
    assign q_signed = cur_sgn ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});

    // Control: state, counters and the slot count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            slot_reg    <= 2'd0;
            mcnt_reg    <= 4'd0;
            comp_reg    <= 2'd0;
            dcnt_reg    <= 4'd0;
            out_cnt_reg <= 2'd0;
            vsel_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        if (slot_reg < SLOT_THIRD)
                        begin
                            slot_reg <= s_tlast ? 2'd0 : slot_reg + 2'd1;
                        end
                        else
                        begin
                            slot_reg  <= 2'd0;
                            state_reg <= ST_REDUCE;
                        end
                    end
                end
                ST_REDUCE:
                begin
                    if (!(e_big || du_big || dv_big))
                    begin
                        mcnt_reg  <= 4'd0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (mcnt_reg == MUL_LAST)
                    begin
                        vsel_reg  <= 1'b0;
                        state_reg <= ST_NSHIFT;
                    end
                    else
                    begin
                        mcnt_reg  <= mcnt_reg + 4'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_NSHIFT:
                begin
                    if (!n_big1)
                    begin
                        comp_reg  <= 2'd0;
                        state_reg <= ST_SQMUL;
                    end
                end
                ST_SQMUL:
                begin
                    state_reg <= ST_SQACC;
                end
                ST_SQACC:
                begin
                    if (comp_reg == LAST_COMP)
                    begin
                        state_reg <= ST_CHKLEN;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= ST_SQMUL;
                    end
                end
                ST_CHKLEN:
                begin
                    state_reg <= (acc_reg == '0) ? ST_FINVEC : ST_SQRT;
                end
                ST_SQRT:
                begin
                    if (sq_b_reg[0])
                    begin
                        comp_reg  <= 2'd0;
                        state_reg <= ST_DIVINIT;
                    end
                end
                ST_DIVINIT:
                begin
                    dcnt_reg  <= 4'd0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (dcnt_reg == DIV_LAST)
                    begin
                        if (comp_reg == LAST_COMP)
                        begin
                            state_reg <= ST_FINVEC;
                        end
                        else
                        begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= ST_DIVINIT;
                        end
                    end
                    else
                    begin
                        dcnt_reg <= dcnt_reg + 4'd1;
                    end
                end
                ST_FINVEC:
                begin
                    if (!vsel_reg && !det_zero_reg)
                    begin
                        vsel_reg  <= 1'b1;
                        state_reg <= ST_NSHIFT;
                    end
                    else
                    begin
                        out_cnt_reg <= 2'd0;
                        state_reg   <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (m_tready)
                    begin
                        if (out_cnt_reg == LAST_BEAT)
                        begin
                            out_cnt_reg <= 2'd0;
                            state_reg   <= ST_IDLE;
                        end
                        else
                        begin
                            out_cnt_reg <= out_cnt_reg + 2'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (slot_reg == 2'd0)
                    begin
                        hi_reg[0] <= in_idx;
                        hp_reg[0] <= in_pos[0];
                        hp_reg[1] <= in_pos[1];
                        hp_reg[2] <= in_pos[2];
                        ht_reg[0] <= in_u;
                        ht_reg[1] <= in_v;
                    end
                    else if (slot_reg == 2'd1)
                    begin
                        hi_reg[1] <= in_idx;
                        hp_reg[3] <= in_pos[0];
                        hp_reg[4] <= in_pos[1];
                        hp_reg[5] <= in_pos[2];
                        ht_reg[2] <= in_u;
                        ht_reg[3] <= in_v;
                    end
                    else
                    begin
                        idx2_reg <= in_idx;
                        for (int i = 0; i < 6; i++)
                        begin
                            e_sgn_reg[i] <= edge_d[i][32];
                            e_mag_reg[i] <= edge_abs[i][31:0];
                        end
                        for (int i = 0; i < 4; i++)
                        begin
                            tx_sgn_reg[i] <= tex_d[i][32];
                            tx_mag_reg[i] <= tex_abs[i][31:0];
                        end
                    end
                end
            end
            ST_REDUCE:
            begin
                if (e_big)
                begin
                    for (int i = 0; i < 6; i++)
                    begin
                        e_mag_reg[i] <= e_mag_reg[i] >> 1;
                    end
                end
                if (du_big)
                begin
                    tx_mag_reg[0] <= tx_mag_reg[0] >> 1;
                    tx_mag_reg[1] <= tx_mag_reg[1] >> 1;
                end
                if (dv_big)
                begin
                    tx_mag_reg[2] <= tx_mag_reg[2] >> 1;
                    tx_mag_reg[3] <= tx_mag_reg[3] >> 1;
                end
            end
            ST_MUL, ST_SQMUL:
            begin
                prod_reg <= mul_p;
            end
            ST_ACC:
            begin
                if (!mcnt_reg[0])
                begin
                    acc_reg <= prod_ext;
                end
                else
                begin
                    // The tangent sign folds in the sign of the determinant,
                    // which comes out of the first product pair.
                    unique case (mcnt_reg[3:1])
                        3'd0:
                        begin
                            det_neg_reg  <= diff_neg;
                            det_zero_reg <= (diff == '0);
                        end
                        3'd1: begin n_sgn_reg[0] <= diff_neg; n_mag_reg[0] <= diff_mag; end
                        3'd2: begin n_sgn_reg[1] <= diff_neg; n_mag_reg[1] <= diff_mag; end
                        3'd3: begin n_sgn_reg[2] <= diff_neg; n_mag_reg[2] <= diff_mag; end
                        3'd4:
                        begin
                            tr_sgn_reg[0] <= diff_neg ^ det_neg_reg;
                            tr_mag_reg[0] <= diff_mag;
                        end
                        3'd5:
                        begin
                            tr_sgn_reg[1] <= diff_neg ^ det_neg_reg;
                            tr_mag_reg[1] <= diff_mag;
                        end
                        3'd6:
                        begin
                            tr_sgn_reg[2] <= diff_neg ^ det_neg_reg;
                            tr_mag_reg[2] <= diff_mag;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_NSHIFT:
            begin
                if (n_big8)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        n_mag_reg[i] <= n_mag_reg[i] >> 8;
                    end
                end
                else if (n_big1)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        n_mag_reg[i] <= n_mag_reg[i] >> 1;
                    end
                end
            end
            ST_SQACC:
            begin
                acc_reg <= ((comp_reg == 2'd0) ? '0 : acc_reg) + prod_ext;
            end
            ST_CHKLEN:
            begin
                sq_x_reg <= acc_reg[63:0];
                sq_r_reg <= '0;
                sq_b_reg <= SQRT_FIRST_BIT;
                if (!vsel_reg)
                begin
                    ok_n_reg <= (acc_reg != '0);
                end
                else
                begin
                    ok_t_reg <= (acc_reg != '0);
                end
                if (acc_reg == '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (!vsel_reg)
                        begin
                            on_reg[i] <= '0;
                        end
                        else
                        begin
                            ot_reg[i] <= '0;
                        end
                    end
                end
            end
            ST_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_x_reg <= sq_x_reg - sq_sum;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_b_reg;
                end
                else
                begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_b_reg <= sq_b_reg >> 2;
            end
            ST_DIVINIT:
            begin
                // Rounded quotient: (|c| * 2^14 + len/2) / len.
                rem_reg <= {2'b00, cur_mag[30:0], 14'd0} + {16'd0, len[31:1]};
                den_reg <= {1'b0, len, 14'd0};
                q_reg   <= '0;
            end
            ST_DIV:
            begin
                if (div_ge)
                begin
                    rem_reg <= rem_reg - den_reg;
                end
                den_reg <= den_reg >> 1;
                q_reg   <= q_next;
                if (dcnt_reg == DIV_LAST)
                begin
                    if (!vsel_reg)
                    begin
                        unique case (comp_reg)
                            2'd0:    on_reg[0] <= q_signed;
                            2'd1:    on_reg[1] <= q_signed;
                            2'd2:    on_reg[2] <= q_signed;
                            default: on_reg[0] <= on_reg[0];
                        endcase
                    end
                    else
                    begin
                        unique case (comp_reg)
                            2'd0:    ot_reg[0] <= q_signed;
                            2'd1:    ot_reg[1] <= q_signed;
                            2'd2:    ot_reg[2] <= q_signed;
                            default: ot_reg[0] <= ot_reg[0];
                        endcase
                    end
                end
            end
            ST_FINVEC:
            begin
                if (!vsel_reg)
                begin
                    if (det_zero_reg)
                    begin
                        ok_t_reg <= 1'b0;
                        for (int i = 0; i < 3; i++)
                        begin
                            ot_reg[i] <= '0;
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            n_sgn_reg[i] <= tr_sgn_reg[i];
                            n_mag_reg[i] <= tr_mag_reg[i];
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result beat.
    out_beat_t   beat;
    logic [15:0] beat_idx;

    always_comb
    begin
        unique case (out_cnt_reg)
            2'd0:    beat_idx = hi_reg[0];
            2'd1:    beat_idx = hi_reg[1];
            2'd2:    beat_idx = idx2_reg;
            default: beat_idx = idx2_reg;
        endcase
        beat.pad              = '0;
        beat.degenerate       = !(ok_n_reg && ok_t_reg);
        beat.handed_negative  = det_neg_reg;
        beat.tangent_z        = ot_reg[2];
        beat.tangent_y        = ot_reg[1];
        beat.tangent_x        = ot_reg[0];
        beat.normal_z         = on_reg[2];
        beat.normal_y         = on_reg[1];
        beat.normal_x         = on_reg[0];
        beat.out_vertex_index = beat_idx;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = beat;
    assign m_tlast  = (out_cnt_reg == LAST_BEAT);

    `TNTG_ASSERT_IMPL(a_one_side, clk, rst_n, m_tvalid, !s_tready)
    `TNTG_ASSERT_NEXT(a_third_starts, clk, rst_n, s_fire && (slot_reg == SLOT_THIRD), state_reg == ST_REDUCE)
    `TNTG_ASSERT_IMPL(a_div_nonzero, clk, rst_n, state_reg == ST_DIV, den_reg != '0)
    `TNTG_ASSERT_IMPL(a_slot_range, clk, rst_n, 1'b1, slot_reg != 2'd3)
    `TNTG_ASSERT_IMPL(a_unit_range, clk, rst_n, m_tvalid, (on_reg[0] <= Q14_ONE) && (on_reg[0] >= -Q14_ONE) && (ot_reg[0] <= Q14_ONE) && (ot_reg[0] >= -Q14_ONE))

endmodule

`default_nettype wire

### verif/tntg_checker.sv
// Checker for the triangle normal and tangent generator: watches both stream
// channels, predicts the three results of each triangle and compares them.
// Depends on tntg_pkg only.
`timescale 1ns / 100ps

module tntg_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [tntg_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [tntg_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    output int                             fail_count,
    output int                             pending_count,
    output int                             triangle_count,
    output int                             degenerate_count
);
    import tntg_pkg::*;

    typedef struct {
        logic [15:0] idx;
        logic [15:0] nx, ny, nz, tx, ty, tz;
        logic        hneg, degen, last;
    } vertex_attr_t;

    vertex_attr_t attr_queue[$];

    // Open triangle held by the predictor.
    logic signed [63:0] open_pos[6];
    logic signed [63:0] open_tex[4];
    logic [15:0]        open_idx[2];
    int unsigned        open_slot;

    function automatic logic [63:0] mag64(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // Common shift toward zero so every magnitude drops below 2^bits.
    function automatic void shrink_group(ref logic signed [63:0] v[6], input int n,
                                         input int bits);
        logic [63:0] m;
        int          s;
        m = 0;
        s = 0;
        for (int i = 0; i < n; i++)
            if (mag64(v[i]) > m) m = mag64(v[i]);
        while ((m >> s) >= (64'd1 << bits)) s++;
        for (int i = 0; i < n; i++)
            v[i] = v[i] < 0 ? -$signed(mag64(v[i]) >> s) : $signed(mag64(v[i]) >> s);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic unit_q14(logic signed [63:0] c[6], output logic [15:0] o[3]);
        logic [63:0] len2, len, q;
        shrink_group(c, 3, 31);
        len2 = 0;
        for (int i = 0; i < 3; i++) len2 += mag64(c[i]) * mag64(c[i]);
        for (int i = 0; i < 3; i++) o[i] = 0;
        if (len2 == 0) return 1'b0;
        len = int_sqrt(len2);
        for (int i = 0; i < 3; i++)
        begin
            q = (mag64(c[i]) * 64'd16384 + len / 2) / len;
            o[i] = c[i] < 0 ? 16'(-q) : 16'(q);
        end
        return 1'b1;
    endfunction

    task automatic take_vertex(logic [S_TDATA_W-1:0] d, logic eol);
        logic signed [63:0] p[3], e[6], du[6], dv[6], nr[6], tr[6];
        logic signed [63:0] det;
        logic [15:0]        n[3], t[3], idx[3];
        logic               ok_n, ok_t;
        vertex_attr_t       a;
        for (int i = 0; i < 3; i++) p[i] = $signed(d[16 + 32 * i +: 32]);
        if (open_slot < 2)
        begin
            open_idx[open_slot] = d[15:0];
            for (int i = 0; i < 3; i++) open_pos[open_slot * 3 + i] = p[i];
            open_tex[open_slot * 2]     = $signed(d[112 +: 32]);
            open_tex[open_slot * 2 + 1] = $signed(d[144 +: 32]);
            open_slot = eol ? 0 : open_slot + 1;
            return;
        end
        open_slot = 0;
        for (int i = 0; i < 3; i++)
        begin
            e[i]     = open_pos[3 + i] - open_pos[i];
            e[3 + i] = p[i] - open_pos[i];
        end
        shrink_group(e, 6, 30);
        du[0] = open_tex[2] - open_tex[0];
        du[1] = $signed(d[112 +: 32]) - open_tex[0];
        dv[0] = open_tex[3] - open_tex[1];
        dv[1] = $signed(d[144 +: 32]) - open_tex[1];
        shrink_group(du, 2, 30);
        shrink_group(dv, 2, 30);
        nr[0] = e[1] * e[5] - e[2] * e[4];
        nr[1] = e[2] * e[3] - e[0] * e[5];
        nr[2] = e[0] * e[4] - e[1] * e[3];
        ok_n = unit_q14(nr, n);
        det = du[0] * dv[1] - du[1] * dv[0];
        for (int i = 0; i < 3; i++)
        begin
            tr[i] = dv[1] * e[i] - dv[0] * e[3 + i];
            if (det < 0) tr[i] = -tr[i];
        end
        if (det != 0)
            ok_t = unit_q14(tr, t);
        else
        begin
            for (int i = 0; i < 3; i++) t[i] = 0;
            ok_t = 1'b0;
        end
        idx[0] = open_idx[0];
        idx[1] = open_idx[1];
        idx[2] = d[15:0];
        for (int k = 0; k < 3; k++)
        begin
            a.idx = idx[k];
            a.nx = n[0]; a.ny = n[1]; a.nz = n[2];
            a.tx = t[0]; a.ty = t[1]; a.tz = t[2];
            a.hneg  = det < 0;
            a.degen = !(ok_n && ok_t);
            a.last  = k == 2;
            attr_queue.push_back(a);
        end
        triangle_count++;
        if (!(ok_n && ok_t)) degenerate_count++;
    endtask

    task automatic match_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_slot        = 0;
            fail_count       = 0;
            triangle_count   = 0;
            degenerate_count = 0;
            attr_queue.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (attr_queue.size() == 0)
                begin
                    $error("result transfer with no expected result, tdata %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    vertex_attr_t a;
                    out_beat_t    b;
                    a = attr_queue.pop_front();
                    b = out_beat_t'(m_tdata);
                    match_field("out_vertex_index", a.idx, b.out_vertex_index);
                    match_field("normal_x", a.nx, b.normal_x);
                    match_field("normal_y", a.ny, b.normal_y);
                    match_field("normal_z", a.nz, b.normal_z);
                    match_field("tangent_x", a.tx, b.tangent_x);
                    match_field("tangent_y", a.ty, b.tangent_y);
                    match_field("tangent_z", a.tz, b.tangent_z);
                    match_field("handed_negative", a.hneg, b.handed_negative);
                    match_field("degenerate", a.degen, b.degenerate);
                    match_field("last_of_run", a.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready) take_vertex(s_tdata, s_tlast);
        end
        pending_count = attr_queue.size();
    end
endmodule

### verif/tb_triangle_normal_tangent_gen.sv
// Testbench top for the triangle normal and tangent generator: drives vertex
// transfers and result backpressure, and gives the verdict.
// Depends on tntg_pkg, tntg_checker and the block itself.
`timescale 1ns / 100ps

module tb_triangle_normal_tangent_gen;
    import tntg_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    int                   fail_count;
    int                   pending_count;
    int                   triangle_count;
    int                   degenerate_count;
    int                   cycle_count;
    int                   sent_vertices;
    bit                   calm_phase;

    // The limit below covers a correct run, stalls included, many times over.
    localparam int CYCLE_LIMIT = 400000;

    triangle_normal_tangent_gen dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    tntg_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .fail_count       (fail_count),
        .pending_count    (pending_count),
        .triangle_count   (triangle_count),
        .degenerate_count (degenerate_count)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        if (!rst_n)
            cycle_count <= 0;
        else
            cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver backpressure: random bursts of stall, none in the calm phase.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (!calm_phase && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // One vertex transfer; waits for the handshake and leaves tvalid high, so
    // the caller lowers it when no item follows straight away.
    task automatic send_vertex(logic [15:0] idx, logic [31:0] px, logic [31:0] py,
                               logic [31:0] pz, logic [31:0] u, logic [31:0] v,
                               logic eol);
        if (!calm_phase && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v, u, pz, py, px, idx};
        s_tlast  <= eol;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_vertices++;
    endtask

    // Waits, sampling away from the rising edge, until no result is owed.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 20000)) - 10000) <<< 16;
            default: return 32'($signed($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    // Random triangle; most are well formed with moderate coordinates, some
    // use full-range words, repeated vertices or flat texcoords.
    task automatic send_random_triangle();
        logic [31:0] p[9], t[6];
        int          mode, flavor;
        mode   = $urandom_range(0, 2);
        flavor = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) p[i] = rand_word(mode);
        for (int i = 0; i < 6; i++) t[i] = rand_word(mode);
        if (flavor == 0) for (int i = 0; i < 3; i++) p[6 + i] = p[i];
        if (flavor == 1) for (int i = 0; i < 2; i++) t[4 + i] = t[i];
        if (flavor == 2) t[5] = t[1];
        for (int k = 0; k < 3; k++)
            send_vertex(16'($urandom), p[3 * k], p[3 * k + 1], p[3 * k + 2],
                        t[2 * k], t[2 * k + 1],
                        (k == 2 && $urandom_range(0, 7) == 0) ||
                        (k < 2 && flavor == 9 && $urandom_range(0, 1) == 0));
    endtask

    initial
    begin
        sent_vertices = 0;
        calm_phase    = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a unit right triangle with a plain UV mapping.
        send_vertex(16'h0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_vertex(16'h0001, 32'h10000, 32'h0, 32'h0, 32'h10000, 32'h0, 1'b0);
        send_vertex(16'hFFFF, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h10000, 1'b1);
        // Mirrored UVs: negative determinant, so negative handedness.
        send_vertex(16'h8000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_vertex(16'h7FFF, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 1'b0);
        send_vertex(16'h1234, 32'h0, 32'h10000, 32'h0, 32'h10000, 32'h0, 1'b0);
        // All coincident points and equal texcoords: both vectors degenerate.
        repeat (3) send_vertex(16'h0042, 32'h7FFFFFFF, 32'h80000000, 32'h1,
                               32'h5, 32'h5, 1'b0);
        // Extreme positions and texcoords, every bit toggled.
        send_vertex(16'hAAAA, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                    32'h80000000, 32'h7FFFFFFF, 1'b0);
        send_vertex(16'h5555, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                    32'h7FFFFFFF, 32'h80000000, 1'b0);
        send_vertex(16'hFFFF, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF,
                    32'h00000000, 32'hFFFFFFFF, 1'b0);
        // Zero determinant with a good normal: tangent alone fails.
        send_vertex(16'h0010, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h20000, 1'b0);
        send_vertex(16'h0011, 32'h10000, 32'h0, 32'h0, 32'h20000, 32'h40000, 1'b0);
        send_vertex(16'h0012, 32'h0, 32'h0, 32'h10000, 32'h30000, 32'h60000, 1'b0);
        // End marker on the first vertex, then on the second: both dropped.
        send_vertex(16'h0020, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 1'b1);
        send_vertex(16'h0021, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 1'b0);
        send_vertex(16'h0022, 32'h9, 32'h2, 32'h3, 32'h4, 32'h5, 1'b1);
        s_tvalid <= 1'b0;

        // Hold off until all results are in, so the block runs from empty.
        wait_drained();

        while (sent_vertices < 130) send_random_triangle();
        calm_phase = 1'b1;
        while (sent_vertices < 180) send_random_triangle();
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (300) @(posedge clk);

        $display("Covered %0d vertex transfers forming %0d triangles, %0d degenerate,",
                 sent_vertices, triangle_count, degenerate_count);
        $display("with random stalls on both channels and dropped partial triangles.");
        if (fail_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
